// ----- hw/rtl/tcrh_pkg.sv -----
package tcrh_pkg;

  // Height format and derived ramp-position widths.
  localparam int HEIGHT_FRAC_BITS = 14;
  localparam int HEIGHT_W = 16;
  localparam int HEIGHT_ONE = 1 << HEIGHT_FRAC_BITS;
  localparam int POS_BITS = HEIGHT_FRAC_BITS + 1;
  localparam int Q_SR = (POS_BITS > 16) ? POS_BITS - 16 : 0;
  localparam int Q_SL = (POS_BITS < 16) ? 16 - POS_BITS : 0;
  localparam int P_W = (HEIGHT_FRAC_BITS + 2 > 17) ? HEIGHT_FRAC_BITS + 2 : 17;
  localparam int PC_W = HEIGHT_FRAC_BITS + 2;
  localparam int QW_W = PC_W + Q_SL;
  localparam int Q_W = 17;
  localparam int LAND_SL_P = (POS_BITS < 14) ? 14 - POS_BITS : 0;
  localparam int LAND_SL_T = (POS_BITS > 14) ? POS_BITS - 14 : 0;
  localparam int CMP_W = P_W + 16;

  // Shade path.
  localparam int SLOPE_W = HEIGHT_W + 2;
  localparam int SHADE_W = 15;
  localparam int GAIN_W = 16;
  localparam int GPROD_W = SLOPE_W + GAIN_W + 1;
  localparam int GAIN_SHIFT = HEIGHT_FRAC_BITS - 2;
  localparam logic [SHADE_W-1:0] SHADE_ONE = 15'd16384;

  // Color ramp path.
  localparam int NUM_STOPS = 9;
  localparam int NUM_SEGS = NUM_STOPS - 1;
  localparam int SEG_W = 3;
  localparam int STOP_IDX_W = 4;
  localparam int DIFF_W = 15;
  localparam int RECIP_W = 22;
  localparam int FQ_W = DIFF_W + RECIP_W - 16;
  localparam int FRAC_W = 17;
  localparam int COLOR_W = 16;
  localparam int BPROD_W = COLOR_W + 1 + FRAC_W + 1;
  localparam int PROD_W = COLOR_W + SHADE_W;
  localparam int CH_W = 8;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;
  localparam logic [PROD_W-1:0] PROD_LIMIT = 31'd1073741824;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHADE_BIAS     = 3'd0,
    REG_SHADE_GAIN     = 3'd1,
    REG_SHADE_MIN      = 3'd2,
    REG_SHADE_MAX      = 3'd3,
    REG_LAND_THRESHOLD = 3'd4
  } reg_index_t;

  localparam logic [SHADE_W-1:0] BIAS_RESET = 15'd13926;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd16384;
  localparam logic [SHADE_W-1:0] MIN_RESET = 15'd9011;
  localparam logic [SHADE_W-1:0] MAX_RESET = 15'd19661;
  localparam logic [SHADE_W-1:0] THRESHOLD_RESET = 15'd7209;

  // Percent to Q1.16, rounded.
  function automatic logic [Q_W-1:0] pos16(input int unsigned pct);
    return Q_W'((pct * 65536 + 50) / 100);
  endfunction

  function automatic logic [COLOR_W-1:0] color16(input int unsigned pct);
    logic [Q_W-1:0] v;
    v = pos16(pct);
    return v[COLOR_W-1:0];
  endfunction

  localparam logic [Q_W-1:0] STOP_POS [NUM_STOPS] = '{
    pos16(0), pos16(34), pos16(44), pos16(47), pos16(52),
    pos16(66), pos16(80), pos16(90), pos16(100)
  };

  localparam longint unsigned SEG_SPAN [NUM_SEGS] = '{
    64'(STOP_POS[1] - STOP_POS[0]), 64'(STOP_POS[2] - STOP_POS[1]),
    64'(STOP_POS[3] - STOP_POS[2]), 64'(STOP_POS[4] - STOP_POS[3]),
    64'(STOP_POS[5] - STOP_POS[4]), 64'(STOP_POS[6] - STOP_POS[5]),
    64'(STOP_POS[7] - STOP_POS[6]), 64'(STOP_POS[8] - STOP_POS[7])
  };

  // Rounded 2^32 / span for each segment.
  localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGS] = '{
    RECIP_W'(((64'd1 << 32) + SEG_SPAN[0] / 2) / SEG_SPAN[0]),
    RECIP_W'(((64'd1 << 32) + SEG_SPAN[1] / 2) / SEG_SPAN[1]),
    RECIP_W'(((64'd1 << 32) + SEG_SPAN[2] / 2) / SEG_SPAN[2]),
    RECIP_W'(((64'd1 << 32) + SEG_SPAN[3] / 2) / SEG_SPAN[3]),
    RECIP_W'(((64'd1 << 32) + SEG_SPAN[4] / 2) / SEG_SPAN[4]),
    RECIP_W'(((64'd1 << 32) + SEG_SPAN[5] / 2) / SEG_SPAN[5]),
    RECIP_W'(((64'd1 << 32) + SEG_SPAN[6] / 2) / SEG_SPAN[6]),
    RECIP_W'(((64'd1 << 32) + SEG_SPAN[7] / 2) / SEG_SPAN[7])
  };

  localparam logic [COLOR_W-1:0] STOP_RGB [NUM_STOPS][3] = '{
    '{color16(4),  color16(10), color16(28)},
    '{color16(10), color16(32), color16(60)},
    '{color16(20), color16(52), color16(78)},
    '{color16(80), color16(74), color16(48)},
    '{color16(34), color16(62), color16(30)},
    '{color16(20), color16(46), color16(22)},
    '{color16(45), color16(40), color16(34)},
    '{color16(60), color16(58), color16(55)},
    '{color16(95), color16(96), color16(98)}
  };

  function automatic logic [COLOR_W-1:0] seg_base(input logic [SEG_W-1:0] seg,
                                                  input logic [1:0] ch);
    return STOP_RGB[{1'b0, seg}][ch];
  endfunction

  function automatic logic signed [COLOR_W:0] seg_delta(input logic [SEG_W-1:0] seg,
                                                       input logic [1:0] ch);
    logic [STOP_IDX_W-1:0] hi;
    hi = {1'b0, seg} + 4'd1;
    return $signed({1'b0, STOP_RGB[hi][ch]}) - $signed({1'b0, STOP_RGB[{1'b0, seg}][ch]});
  endfunction

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height_here;
    logic signed [HEIGHT_W-1:0] height_right;
    logic signed [HEIGHT_W-1:0] height_below;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_out_t;

  typedef struct packed {
    logic [SHADE_W-1:0] shade_bias;
    logic [GAIN_W-1:0]  shade_gain;
    logic [SHADE_W-1:0] shade_min;
    logic [SHADE_W-1:0] shade_max;
  } shade_cfg_t;

  // Classified pixel handed from the front end to the back end.
  typedef struct packed {
    logic [SEG_W-1:0]          seg;
    logic [DIFF_W-1:0]         diff;
    logic                      land;
    logic signed [SLOPE_W-1:0] slope;
  } item_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

endpackage

// ----- hw/rtl/tcrh_front.sv -----
module tcrh_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tcrh_pkg::pixel_in_t             in_data,
  input  logic [tcrh_pkg::SHADE_W-1:0]    land_threshold,
  output logic                            item_valid,
  input  logic                            item_ready,
  output tcrh_pkg::item_t                 item
);
  import tcrh_pkg::*;

  logic signed [P_W-1:0]   p;
  logic [PC_W-1:0]         pc;
  logic [QW_W-1:0]         qw;
  logic [Q_W-1:0]          q;
  logic [SEG_W-1:0]        seg;
  logic [Q_W-1:0]          diff_full;
  logic signed [CMP_W-1:0] land_lhs;
  logic signed [CMP_W-1:0] land_rhs;
  item_t                   item_next;

  always_comb begin
    p = P_W'(in_data.height_here) + P_W'(HEIGHT_ONE);
    if (p < 0) begin
      pc = '0;
    end else if (p > P_W'(2 * HEIGHT_ONE)) begin
      pc = PC_W'(2 * HEIGHT_ONE);
    end else begin
      pc = PC_W'(p);
    end
    qw = (QW_W'(pc) >> Q_SR) << Q_SL;
    q = qw[Q_W-1:0];

    // First stop at or above the position picks the segment; the last one catches the rest.
    seg = SEG_W'(NUM_SEGS - 1);
    for (int k = NUM_SEGS - 1; k >= 1; k--) begin
      if (q <= STOP_POS[k]) begin
        seg = SEG_W'(k - 1);
      end
    end
    diff_full = q - STOP_POS[{1'b0, seg}];

    // The land test uses the unclamped position.
    land_lhs = CMP_W'(p) <<< LAND_SL_P;
    land_rhs = $signed(CMP_W'(land_threshold)) <<< LAND_SL_T;

    item_next.seg = seg;
    item_next.diff = diff_full[DIFF_W-1:0];
    item_next.land = (land_lhs > land_rhs);
    item_next.slope = (SLOPE_W'(in_data.height_here) - SLOPE_W'(in_data.height_right)) +
                      (SLOPE_W'(in_data.height_here) - SLOPE_W'(in_data.height_below));
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// ----- hw/rtl/tcrh_queue.sv -----
module tcrh_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tcrh_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output tcrh_pkg::item_t out_item
);
  import tcrh_pkg::*;

  item_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   push;
  logic                   pop;

  assign in_ready = (count != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// ----- hw/rtl/tcrh_back.sv -----
module tcrh_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tcrh_pkg::item_t      item,
  input  tcrh_pkg::shade_cfg_t shade_cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcrh_pkg::pixel_out_t out_data
);
  import tcrh_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage 1: fraction and slope products.
  logic [DIFF_W+RECIP_W-1:0]  fprod;
  logic signed [GPROD_W-1:0]  gprod;
  logic [SEG_W-1:0]           seg1;
  logic                       land1;
  logic [FQ_W-1:0]            fq1;
  logic signed [GPROD_W-1:0]  gprod1;

  // Stage 2: saturated fraction and clamped shade.
  logic signed [GPROD_W:0]    shade_sum;
  logic [FRAC_W-1:0]          f_next;
  logic [SHADE_W-1:0]         s_next;
  logic [SEG_W-1:0]           seg2;
  logic [FRAC_W-1:0]          f2;
  logic [SHADE_W-1:0]         s2;

  // Stage 3: blended color.
  logic signed [BPROD_W-1:0]  bprod [3];
  logic signed [BPROD_W-1:0]  col_sum [3];
  logic [COLOR_W-1:0]         col3 [3];
  logic [SHADE_W-1:0]         s3;

  // Stage 4: shaded and limited product.
  logic [PROD_W-1:0]          prod [3];
  logic [PROD_W-1:0]          prod4 [3];

  // Stage 5: scale to 8 bits.
  logic [PROD_W+8-1:0]        scaled [3];
  pixel_out_t                 out_next;

  assign rdy5 = !out_valid || out_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign item_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= item_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        out_valid <= v4;
      end
    end
  end

  always_comb begin
    fprod = item.diff * SEG_RECIP[item.seg];
    gprod = item.slope * $signed({1'b0, shade_cfg.shade_gain});
  end

  always_ff @(posedge clk) begin
    if (rdy1 && item_valid) begin
      seg1 <= item.seg;
      land1 <= item.land;
      fq1 <= fprod[DIFF_W+RECIP_W-1:16];
      gprod1 <= gprod;
    end
  end

  always_comb begin
    f_next = (fq1 > FQ_W'(FRAC_ONE)) ? FRAC_ONE : fq1[FRAC_W-1:0];
    // Slope term is floored to 14 fraction bits before the bias is added.
    shade_sum = $signed({1'b0, shade_cfg.shade_bias}) + (gprod1 >>> GAIN_SHIFT);
    if (!land1) begin
      s_next = SHADE_ONE;
    end else if (shade_sum < $signed({1'b0, shade_cfg.shade_min})) begin
      s_next = shade_cfg.shade_min;
    end else if (shade_sum > $signed({1'b0, shade_cfg.shade_max})) begin
      s_next = shade_cfg.shade_max;
    end else begin
      s_next = shade_sum[SHADE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      seg2 <= seg1;
      f2 <= f_next;
      s2 <= s_next;
    end
  end

  // Blend as base plus floored delta times fraction, which matches the two-term form.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bprod[c] = seg_delta(seg2, 2'(c)) * $signed({1'b0, f2});
      col_sum[c] = $signed({1'b0, seg_base(seg2, 2'(c))}) + (bprod[c] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int c = 0; c < 3; c++) begin
        col3[c] <= col_sum[c][COLOR_W-1:0];
      end
      s3 <= s2;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = col3[c] * s3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      for (int c = 0; c < 3; c++) begin
        prod4[c] <= (prod[c] > PROD_LIMIT) ? PROD_LIMIT : prod[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scaled[c] = ((PROD_W + 8)'(prod4[c]) << 8) - (PROD_W + 8)'(prod4[c]);
    end
    out_next.red = scaled[0][PROD_W+6:PROD_W-1];
    out_next.green = scaled[1][PROD_W+6:PROD_W-1];
    out_next.blue = scaled[2][PROD_W+6:PROD_W-1];
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      out_data <= out_next;
    end
  end

endmodule

// ----- hw/rtl/terrain_color_ramp_hillshade.sv -----
// Terrain colorizer: each transfer on the input carries a height sample and its right and
// lower neighbors (signed Q2.14); each output transfer carries the 8-bit RGB color of that
// pixel, in order, one result per input. The height picks a place on a nine-stop color ramp
// from deep water to snow, and land pixels are scaled by a hillshade factor built from the
// forward-difference slope and the registers shade_bias (index 0), shade_gain (1),
// shade_min (2), shade_max (3) and land_threshold (4); write them only while no pixel is in
// flight. The block takes one pixel every clock cycle and returns one every cycle while the
// output side keeps up; a pixel passes one classify register, one queue slot and five
// arithmetic stages, the depth being set by the chain of fraction, blend and shade
// multipliers. A two-entry queue between the classifier and the arithmetic pipeline,
// plus full-rate stage handshakes, keep the input moving while a finished pixel waits.
module terrain_color_ramp_hillshade (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tcrh_pkg::pixel_in_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tcrh_pkg::pixel_out_t               out_data,
  input  logic                               cfg_write,
  input  logic [tcrh_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tcrh_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tcrh_pkg::*;

  logic [SHADE_W-1:0] shade_bias;
  logic [GAIN_W-1:0]  shade_gain;
  logic [SHADE_W-1:0] shade_min;
  logic [SHADE_W-1:0] shade_max;
  logic [SHADE_W-1:0] land_threshold;
  shade_cfg_t         shade_cfg;

  logic  front_valid;
  logic  front_ready;
  item_t front_item;
  logic  queue_valid;
  logic  queue_ready;
  item_t queue_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      shade_bias <= BIAS_RESET;
      shade_gain <= GAIN_RESET;
      shade_min <= MIN_RESET;
      shade_max <= MAX_RESET;
      land_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SHADE_BIAS: begin
          shade_bias <= cfg_data[SHADE_W-1:0];
        end
        REG_SHADE_GAIN: begin
          shade_gain <= cfg_data[GAIN_W-1:0];
        end
        REG_SHADE_MIN: begin
          shade_min <= cfg_data[SHADE_W-1:0];
        end
        REG_SHADE_MAX: begin
          shade_max <= cfg_data[SHADE_W-1:0];
        end
        REG_LAND_THRESHOLD: begin
          land_threshold <= cfg_data[SHADE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    shade_cfg.shade_bias = shade_bias;
    shade_cfg.shade_gain = shade_gain;
    shade_cfg.shade_min = shade_min;
    shade_cfg.shade_max = shade_max;
  end

  tcrh_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .land_threshold (land_threshold),
    .item_valid     (front_valid),
    .item_ready     (front_ready),
    .item           (front_item)
  );

  tcrh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_item  (queue_item)
  );

  tcrh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .shade_cfg  (shade_cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
